@@ rtl/smr_pkg.sv @@
// Shared types and constants for the spiral matrix reorder block.
`timescale 1ns / 1ps
`default_nettype none
package smr_pkg;

  localparam int CNT_W     = 5;          // width of a row or column count
  localparam int IDX_W     = 4;          // width of an emitted row or column index
  localparam int PROD_W    = 2 * CNT_W;  // width of a count product
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } pos_t;

endpackage
`default_nettype wire

@@ rtl/smr_mem.sv @@
// Matrix store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module smr_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/smr_ctrl.sv @@
// Count registers, load pointer and spiral walker producing store addresses.
`timescale 1ns / 1ps
`default_nettype none
module smr_ctrl #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16,
  parameter int AW       = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_wr_i,
  input  wire logic [smr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [smr_pkg::CNT_W-1:0]      cfg_data_i,
  input  wire logic                           load_i,
  input  wire logic                           emit_i,
  output logic      [AW-1:0]                  wr_addr_o,
  output logic      [AW-1:0]                  rd_addr_o,
  output smr_pkg::pos_t                       pos_o
);

  localparam int CW = smr_pkg::CNT_W;
  localparam int PW = smr_pkg::PROD_W;
  localparam int RowCap = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
  localparam int ColCap = (MAX_COLS > 31) ? 31 : MAX_COLS;
  localparam int RowRst = (RowCap < 16) ? RowCap : 16;
  localparam int ColRst = (ColCap < 16) ? ColCap : 16;
  localparam logic [CW-1:0] RowCapV = CW'(RowCap);
  localparam logic [CW-1:0] ColCapV = CW'(ColCap);
  localparam logic [CW-1:0] RowRstV = CW'(RowRst);
  localparam logic [CW-1:0] ColRstV = CW'(ColRst);

  logic [CW-1:0] rc_q, rc_d, cc_q, cc_d;
  logic [PW-1:0] lp_q, lp_d, lp_nxt;
  smr_pkg::dir_e dir_q, dir_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] bot_q, bot_d, top_q, top_d, lft_q, lft_d, rgt_q, rgt_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PW-1:0] total, rd_lin;
  logic          is_last, restart;

  // Clamped count writes; a zero count is taken as one.
  always_comb begin
    rc_d = rc_q;
    cc_d = cc_q;
    if (cfg_wr_i && cfg_idx_i == smr_pkg::CFG_ROW_COUNT) begin
      if (cfg_data_i == '0) begin
        rc_d = CW'(1);
      end else if (cfg_data_i > RowCapV) begin
        rc_d = RowCapV;
      end else begin
        rc_d = cfg_data_i;
      end
    end
    if (cfg_wr_i && cfg_idx_i == smr_pkg::CFG_COL_COUNT) begin
      if (cfg_data_i == '0) begin
        cc_d = CW'(1);
      end else if (cfg_data_i > ColCapV) begin
        cc_d = ColCapV;
      end else begin
        cc_d = cfg_data_i;
      end
    end
  end

  assign restart = cfg_wr_i &&
                   (cfg_idx_i == smr_pkg::CFG_ROW_COUNT || cfg_idx_i == smr_pkg::CFG_COL_COUNT);
  assign total   = PW'(rc_q) * PW'(cc_q);
  assign rd_lin  = PW'(row_q) * PW'(cc_q) + PW'(col_q);
  assign is_last = (rem_q == PW'(1));

  assign lp_nxt = lp_q + PW'(1);

  always_comb begin
    lp_d = lp_q;
    if (restart) begin
      lp_d = '0;
    end else if (load_i) begin
      lp_d = (lp_nxt >= total) ? '0 : lp_nxt;
    end
  end

  // Spiral walker: bottom row leftward, up, top row rightward, down, inward.
  always_comb begin
    dir_d = dir_q;
    row_d = row_q;
    col_d = col_q;
    bot_d = bot_q;
    top_d = top_q;
    lft_d = lft_q;
    rgt_d = rgt_q;
    rem_d = rem_q;
    if (restart || (emit_i && is_last)) begin
      dir_d = smr_pkg::DIR_LEFT;
      row_d = rc_d - CW'(1);
      col_d = cc_d - CW'(1);
      bot_d = rc_d - CW'(1);
      rgt_d = cc_d - CW'(1);
      top_d = '0;
      lft_d = '0;
      rem_d = PW'(rc_d) * PW'(cc_d);
    end else if (emit_i) begin
      rem_d = rem_q - PW'(1);
      unique case (dir_q)
        smr_pkg::DIR_LEFT: begin
          if (col_q > lft_q) begin
            col_d = col_q - CW'(1);
          end else begin
            bot_d = bot_q - CW'(1);
            dir_d = smr_pkg::DIR_UP;
            row_d = bot_q - CW'(1);
            col_d = lft_q;
          end
        end
        smr_pkg::DIR_UP: begin
          if (row_q > top_q) begin
            row_d = row_q - CW'(1);
          end else begin
            lft_d = lft_q + CW'(1);
            dir_d = smr_pkg::DIR_RIGHT;
            row_d = top_q;
            col_d = lft_q + CW'(1);
          end
        end
        smr_pkg::DIR_RIGHT: begin
          if (col_q < rgt_q) begin
            col_d = col_q + CW'(1);
          end else begin
            top_d = top_q + CW'(1);
            dir_d = smr_pkg::DIR_DOWN;
            row_d = top_q + CW'(1);
            col_d = rgt_q;
          end
        end
        smr_pkg::DIR_DOWN: begin
          if (row_q < bot_q) begin
            row_d = row_q + CW'(1);
          end else begin
            rgt_d = rgt_q - CW'(1);
            dir_d = smr_pkg::DIR_LEFT;
            row_d = bot_q;
            col_d = rgt_q - CW'(1);
          end
        end
        default: begin
          dir_d = smr_pkg::DIR_LEFT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= RowRstV;
      cc_q  <= ColRstV;
      lp_q  <= '0;
      dir_q <= smr_pkg::DIR_LEFT;
      row_q <= RowRstV - CW'(1);
      col_q <= ColRstV - CW'(1);
      bot_q <= RowRstV - CW'(1);
      rgt_q <= ColRstV - CW'(1);
      top_q <= '0;
      lft_q <= '0;
      rem_q <= PW'(RowRst * ColRst);
    end else begin
      rc_q  <= rc_d;
      cc_q  <= cc_d;
      lp_q  <= lp_d;
      dir_q <= dir_d;
      row_q <= row_d;
      col_q <= col_d;
      bot_q <= bot_d;
      rgt_q <= rgt_d;
      top_q <= top_d;
      lft_q <= lft_d;
      rem_q <= rem_d;
    end
  end

  assign wr_addr_o  = AW'(lp_q);
  assign rd_addr_o  = AW'(rd_lin);
  assign pos_o.row  = row_q[smr_pkg::IDX_W-1:0];
  assign pos_o.col  = col_q[smr_pkg::IDX_W-1:0];
  assign pos_o.last = is_last;

endmodule
`default_nettype wire

@@ rtl/spiral_matrix_reorder_top.sv @@
// Top level of the spiral matrix reorder block.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries operation_i and value_i.
//   A load transfer writes value_i at the next row-major position and gives
//   no result; the load pointer wraps after row_count * col_count loads.
//   An emit transfer gives one result on the output channel
//   (out_valid_o/out_ready_i): the element at the next spiral position with
//   its row, column and a last flag; after the last one the spiral restarts.
//   Config channel (cfg_valid_i/cfg_ready_o) writes row_count (index 0) or
//   col_count (index 1); counts are clamped and the spiral and load pointer
//   restart. Always ready. Write only while the block is idle.
// Timing: the store is read at the emit transfer edge into its registered read
//   data, which then moves into the output register where out_valid_o rises.
//   An emit blocks the input until its data reaches the output register, and
//   loads run at one per cycle while no emit read is in flight and the output
//   is free. The input stalls while a result waits in the output register and
//   the receiver holds out_ready_i low.
// Reset: counts return to their defaults, pointer and spiral restart; the
//   stored matrix is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module spiral_matrix_reorder_top #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                operation_i,
  input  wire logic signed [DATA_WIDTH-1:0]        value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [DATA_WIDTH-1:0]             element_o,
  output logic        [smr_pkg::IDX_W-1:0]         row_index_o,
  output logic        [smr_pkg::IDX_W-1:0]         col_index_o,
  output logic                                     last_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [smr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [smr_pkg::CNT_W-1:0]     cfg_data_i
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic                  in_fire, load_fire, emit_fire, cfg_fire;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  smr_pkg::pos_t         pos, rd_pos_q;
  logic                  rd_vld_q, out_vld_q;
  logic [DATA_WIDTH-1:0] elem_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_ready_o  = !rd_vld_q && (!out_vld_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign emit_fire   = in_fire && (operation_i == smr_pkg::OP_EMIT);
  assign load_fire   = in_fire && (operation_i == smr_pkg::OP_LOAD);

  smr_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_fire),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .load_i     (load_fire),
    .emit_i     (emit_fire),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .pos_o      (pos)
  );

  smr_mem #(
    .DEPTH (Depth),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (wr_addr),
    .wdata_i (value_i),
    .re_i    (emit_fire),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Read stage: position travels alongside the memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= emit_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      rd_pos_q <= pos;
    end
  end

  // Output register; the input gating keeps it free when the read lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rd_vld_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  smr_pkg::pos_t out_pos_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      elem_q    <= rd_data;
      out_pos_q <= rd_pos_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign element_o   = elem_q;
  assign row_index_o = out_pos_q.row;
  assign col_index_o = out_pos_q.col;
  assign last_o      = out_pos_q.last;

endmodule
`default_nettype wire
